[design/gcc_pkg.sv]
`default_nettype none
package gcc_pkg;

    localparam int VAL_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int USE_W         = 3;
    localparam int NUM_COINS_DEF = 4;
    localparam int NUM_COINS_MAX = 4;
    localparam int COIN_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COINS_IN_USE = 3'd4;
    localparam logic [USE_W-1:0]     USE_RESET        = 3'd4;

    typedef struct packed {
        logic load;
        logic next;
        logic div_start;
        logic div_step;
        logic emit_coin;
        logic emit_sum;
    } t_cmd;

    typedef struct packed {
        logic rem_zero;
        logic idx_end;
        logic coin_zero;
        logic div_last;
        logic cnt_zero;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

[design/gcc_if.sv]
`default_nettype none
interface gcc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] amount;

    modport source (output valid, output amount, input ready);
    modport sink (input valid, input amount, output ready);
endinterface

interface gcc_out_if;
    logic        valid;
    logic        ready;
    logic        is_summary;
    logic [1:0]  coin_index;
    logic [15:0] coin_value;
    logic [15:0] coin_count;
    logic [15:0] total_coins;
    logic        found;
    logic        last;

    modport source (
        output valid, output is_summary, output coin_index, output coin_value,
        output coin_count, output total_coins, output found, output last,
        input ready
    );
    modport sink (
        input valid, input is_summary, input coin_index, input coin_value,
        input coin_count, input total_coins, input found, input last,
        output ready
    );
endinterface
`default_nettype wire

[design/gcc_datapath.sv]
`default_nettype none
module gcc_datapath #(
    parameter int NUM_COINS = gcc_pkg::NUM_COINS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [gcc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [gcc_pkg::VAL_W-1:0]        i_cfg_data,
    input  wire  [gcc_pkg::VAL_W-1:0]        i_amount,
    input  gcc_pkg::t_cmd                    i_cmd,
    output gcc_pkg::t_status                 o_status,
    gcc_out_if.source                        o_out_ch
);
    import gcc_pkg::*;

    localparam int IDX_W = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
    localparam int CNT_W = $clog2(VAL_W);
    localparam logic [USE_W-1:0] NC = USE_W'(NUM_COINS);

    logic [VAL_W-1:0] r_coin [NUM_COINS];
    logic [USE_W-1:0] r_use;
    logic [USE_W-1:0] r_idx;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_total;
    logic [VAL_W-1:0] r_divisor;
    logic [VAL_W-1:0] r_part;
    logic [VAL_W-1:0] r_quot;
    logic [CNT_W-1:0] r_bits;

    logic             r_out_valid;
    logic             r_out_summary;
    logic [COIN_IDX_W-1:0] r_out_index;
    logic [VAL_W-1:0] r_out_value;
    logic [VAL_W-1:0] r_out_count;
    logic [VAL_W-1:0] r_out_total;
    logic             r_out_found;

    logic [USE_W-1:0] limit;
    logic [VAL_W-1:0] coin_sel;
    logic [VAL_W:0]   part_sh;
    logic             ge;
    logic [VAL_W-1:0] n_part;
    logic [VAL_W-1:0] n_quot;
    logic [VAL_W-1:0] n_total;

    assign limit    = (r_use > NC) ? NC : r_use;
    assign coin_sel = r_coin[r_idx[IDX_W-1:0]];

    // one restoring step per cycle
    always_comb begin
        part_sh = {r_part, r_quot[VAL_W-1]};
        ge      = part_sh >= {1'b0, r_divisor};
        n_part  = ge ? VAL_W'(part_sh - {1'b0, r_divisor}) : part_sh[VAL_W-1:0];
        n_quot  = {r_quot[VAL_W-2:0], ge};
        n_total = r_total + r_quot;
    end

    assign o_status.rem_zero  = (r_rem == '0);
    assign o_status.idx_end   = (r_idx >= limit);
    assign o_status.coin_zero = (coin_sel == '0);
    assign o_status.div_last  = (r_bits == '0);
    assign o_status.cnt_zero  = (r_quot == '0);
    assign o_status.out_free  = !r_out_valid || o_out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COINS; k++) begin
                r_coin[k] <= '0;
            end
            r_use       <= USE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx < CFG_IDX_W'(NUM_COINS)) begin
                    r_coin[i_cfg_idx[IDX_W-1:0]] <= i_cfg_data;
                end else if (i_cfg_idx == CFG_COINS_IN_USE) begin
                    r_use <= i_cfg_data[USE_W-1:0];
                end
            end
            if (i_cmd.emit_coin || i_cmd.emit_sum) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= i_amount;
            r_total <= '0;
            r_idx   <= '0;
        end
        if (i_cmd.next) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.div_start) begin
            r_divisor <= coin_sel;
            r_part    <= '0;
            r_quot    <= r_rem;
            r_bits    <= CNT_W'(VAL_W - 1);
        end
        if (i_cmd.div_step) begin
            r_part <= n_part;
            r_quot <= n_quot;
            r_bits <= r_bits - 1'b1;
            if (r_bits == '0) begin
                r_rem <= n_part;
            end
        end
        if (i_cmd.emit_coin) begin
            r_total       <= n_total;
            r_out_summary <= 1'b0;
            r_out_index   <= r_idx[COIN_IDX_W-1:0];
            r_out_value   <= r_divisor;
            r_out_count   <= r_quot;
            r_out_total   <= n_total;
            r_out_found   <= 1'b0;
        end
        if (i_cmd.emit_sum) begin
            r_out_summary <= 1'b1;
            r_out_index   <= '0;
            r_out_value   <= '0;
            r_out_count   <= '0;
            r_out_total   <= r_total;
            r_out_found   <= (r_rem == '0);
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.is_summary  = r_out_summary;
    assign o_out_ch.coin_index  = r_out_index;
    assign o_out_ch.coin_value  = r_out_value;
    assign o_out_ch.coin_count  = r_out_count;
    assign o_out_ch.total_coins = r_out_total;
    assign o_out_ch.found       = r_out_found;
    assign o_out_ch.last        = r_out_summary;

endmodule
`default_nettype wire

[design/gcc_ctrl.sv]
`default_nettype none
module gcc_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  gcc_pkg::t_status  i_status,
    output gcc_pkg::t_cmd     o_cmd
);
    import gcc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EMIT,
        S_SUMMARY
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.idx_end || i_status.rem_zero) begin
                    n_state = S_SUMMARY;
                end else if (i_status.coin_zero) begin
                    o_cmd.next = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.cnt_zero) begin
                    o_cmd.next = 1'b1;
                    n_state    = S_CHECK;
                end else if (i_status.out_free) begin
                    o_cmd.emit_coin = 1'b1;
                    o_cmd.next      = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_SUMMARY: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sum = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[design/greedy_coin_change.sv]
`default_nettype none
// Greedy coin change: an accepted amount is split over the configured coin values,
// in coin index order, giving one beat per coin with a nonzero count and then a summary
// beat (last = 1) with the total coin count and whether the amount was paid exactly. One
// amount is in work at a time. Each examined nonzero coin passes a check step, the shared
// restoring divider (one quotient bit per cycle) and an emit step that waits while the
// output register still holds a beat not yet taken; a zero coin is skipped in the check
// step. Result beats sit in an output register. The user must write coin values and
// coins_in_use only while idle; the block itself does not enforce this.
module greedy_coin_change #(
    parameter int NUM_COINS = gcc_pkg::NUM_COINS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [gcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [gcc_pkg::VAL_W-1:0]      i_cfg_data,
    gcc_in_if.sink                         i_in_ch,
    gcc_out_if.source                      o_out_ch
);
    import gcc_pkg::*;

    t_cmd    cmd;
    t_status status;

    gcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (i_in_ch.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gcc_datapath #(
        .NUM_COINS (NUM_COINS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_amount   (i_in_ch.amount),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_ch   (o_out_ch)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.emit_coin, cmd.emit_sum}))
        else $error("more than one datapath command");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ch.valid && i_in_ch.ready |=> !i_in_ch.ready)
        else $error("ready while an amount is in work");

    a_div_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !status.coin_zero && !status.rem_zero && !status.idx_end)
        else $error("division started on a skipped coin");

    a_emit_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_coin || cmd.emit_sum |-> status.out_free)
        else $error("beat written over a pending beat");

endmodule
`default_nettype wire
